@@ hw/rtl/keyed_job_table_with_compaction_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef KEYED_JOB_TABLE_WITH_COMPACTION_DEFINES_SVH
`define KEYED_JOB_TABLE_WITH_COMPACTION_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define KJT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kjt: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define KJT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kjt: next-cycle check failed");

`endif

@@ hw/rtl/kjt_pkg.sv @@
package kjt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int KEY_BITS    = 22;

   localparam int PID_W   = 22;
   localparam int JOB_W   = 16;
   localparam int STATE_W = 2;
   localparam int OP_W    = 3;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 5;
   localparam int STAT_W  = 2;

   localparam int KEY_W = (KEY_BITS < PID_W) ? KEY_BITS : PID_W;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE    = 3'd1;
   localparam logic [OP_W-1:0] OP_SET_STATE = 3'd2;
   localparam logic [OP_W-1:0] OP_QUERY_KEY = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY_JOB = 3'd4;
   localparam logic [OP_W-1:0] OP_COUNT     = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

   localparam logic [STATE_W-1:0] JOB_RUNNING = 2'd0;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [PID_W-1:0]   pid_key;
      logic [JOB_W-1:0]   job_number;
      logic [STATE_W-1:0] new_state;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [SLOT_W-1:0]  slot_index;
      logic [PID_W-1:0]   key_out;
      logic [JOB_W-1:0]   job_out;
      logic [STATE_W-1:0] state_out;
      logic [COUNT_W-1:0] entry_count;
      logic [STAT_W-1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [JOB_W-1:0]   job;
      logic [STATE_W-1:0] state;
   } entry_type;

   // Command travelling down the cell chain, one cell per cycle.
   typedef struct packed {
      logic             active;
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      logic [JOB_W-1:0] job;
      logic [STATE_W-1:0] nst;
      logic [IDX_W-1:0] cur;
      logic             hit;
      logic             dup;
      logic [IDX_W-1:0] pos;
      entry_type        ent;
   } token_type;

endpackage

@@ hw/rtl/kjt_cell.sv @@
module kjt_cell (
   input  logic              clock,
   input  logic              reset,
   input  kjt_pkg::token_type tok_i,
   output kjt_pkg::token_type tok_o,
   input  logic              nxt_valid,
   input  kjt_pkg::entry_type nxt_entry,
   output logic              valid_o,
   output kjt_pkg::entry_type entry_o
);
   import kjt_pkg::*;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   token_type tok_ff, tok_in;
   logic      key_hit, job_hit;

   assign key_hit = valid_ff && (entry_ff.key == tok_i.key);
   assign job_hit = valid_ff && (entry_ff.job == tok_i.job);

   always_comb begin
      valid_in   = valid_ff;
      entry_in   = entry_ff;
      tok_in     = tok_i;
      tok_in.cur = tok_i.cur + 1'b1;
      if (tok_i.active) begin
         case (tok_i.op)
            OP_INSERT: begin
               if (!tok_i.hit) begin
                  if (key_hit) begin
                     tok_in.hit = 1'b1;
                     tok_in.dup = 1'b1;
                     tok_in.pos = tok_i.cur;
                     tok_in.ent = entry_ff;
                  end else if (!valid_ff) begin
                     // first free cell: no later cell can hold the key
                     valid_in       = 1'b1;
                     entry_in.key   = tok_i.key;
                     entry_in.job   = tok_i.job;
                     entry_in.state = JOB_RUNNING;
                     tok_in.hit     = 1'b1;
                     tok_in.pos     = tok_i.cur;
                     tok_in.ent     = entry_in;
                  end
               end
            end
            OP_DELETE: begin
               if (tok_i.hit || key_hit) begin
                  valid_in = nxt_valid;
                  entry_in = nxt_entry;
               end
               if (!tok_i.hit && key_hit) begin
                  tok_in.hit = 1'b1;
                  tok_in.pos = tok_i.cur;
                  tok_in.ent = entry_ff;
               end
            end
            OP_SET_STATE: begin
               if (!tok_i.hit && key_hit) begin
                  entry_in.state = tok_i.nst;
                  tok_in.hit     = 1'b1;
                  tok_in.pos     = tok_i.cur;
                  tok_in.ent     = entry_in;
               end
            end
            OP_QUERY_KEY: begin
               if (!tok_i.hit && key_hit) begin
                  tok_in.hit = 1'b1;
                  tok_in.pos = tok_i.cur;
                  tok_in.ent = entry_ff;
               end
            end
            OP_QUERY_JOB: begin
               if (!tok_i.hit && job_hit) begin
                  tok_in.hit = 1'b1;
                  tok_in.pos = tok_i.cur;
                  tok_in.ent = entry_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign tok_o   = tok_ff;
   assign valid_o = valid_ff;
   assign entry_o = entry_ff;

endmodule

@@ hw/rtl/keyed_job_table_with_compaction.sv @@
// Ordered key/job table built as a chain of TABLE_DEPTH cells, one entry per
// cell. A command word enters the first cell and walks the chain one cell per
// cycle; each cell compares, writes, or (on delete) takes its right neighbor's
// entry as the command passes, so order is kept without a separate shift pass.
// One command is in flight at a time: the result word goes from the last cell
// into a hold register and then into the output register, and the next command
// is taken once the result has moved into the output register. A finished result
// may sit stalled in the output register while the next command runs. Entries
// never written read as don't-care and are never reported.
module keyed_job_table_with_compaction (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kjt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kjt_pkg::rsp_type rsp_data
);
   import kjt_pkg::*;

   token_type tok     [TABLE_DEPTH];
   token_type tok_src [TABLE_DEPTH];
   logic      cvalid  [TABLE_DEPTH];
   entry_type centry  [TABLE_DEPTH];
   logic      nvalid  [TABLE_DEPTH];
   entry_type nentry  [TABLE_DEPTH];

   logic             busy_ff, busy_in;
   logic             hold_valid_ff, hold_valid_in;
   rsp_type          hold_ff, hold_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept, move;
   token_type        start;
   token_type        last;

   assign accept = req_valid && !req_stall;
   assign req_stall = busy_ff;

   always_comb begin
      start        = '0;
      start.active = accept;
      start.op     = req_data.operation;
      start.key    = req_data.pid_key[KEY_W-1:0];
      start.job    = req_data.job_number;
      start.nst    = req_data.new_state;
   end

   genvar gi;
   generate
      for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
         if (gi == 0) begin : g_first
            assign tok_src[gi] = start;
         end else begin : g_mid
            assign tok_src[gi] = tok[gi-1];
         end
         if (gi == TABLE_DEPTH - 1) begin : g_end
            assign nvalid[gi] = 1'b0;
            assign nentry[gi] = '0;
         end else begin : g_link
            assign nvalid[gi] = cvalid[gi+1];
            assign nentry[gi] = centry[gi+1];
         end
         kjt_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .tok_i    (tok_src[gi]),
            .tok_o    (tok[gi]),
            .nxt_valid(nvalid[gi]),
            .nxt_entry(nentry[gi]),
            .valid_o  (cvalid[gi]),
            .entry_o  (centry[gi])
         );
      end
   endgenerate

   assign last = tok[TABLE_DEPTH-1];
   assign move = hold_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      count_in      = count_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff && !move;
      busy_in       = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (move) begin
         busy_in = 1'b0;
      end
      if (last.active) begin
         if (last.hit && (last.op == OP_INSERT) && !last.dup) begin
            count_in = count_ff + 1'b1;
         end else if (last.hit && (last.op == OP_DELETE)) begin
            count_in = count_ff - 1'b1;
         end
         hold_valid_in       = 1'b1;
         hold_in             = '0;
         hold_in.entry_count = COUNT_W'(count_in);
         if (last.hit) begin
            hold_in.found      = 1'b1;
            hold_in.slot_index = SLOT_W'(last.pos);
            hold_in.key_out    = PID_W'(last.ent.key);
            hold_in.job_out    = last.ent.job;
            hold_in.state_out  = last.ent.state;
            hold_in.status     = last.dup ? ST_MISS : ST_OK;
         end else if (last.op == OP_INSERT) begin
            hold_in.status = ST_FULL;
         end else if (last.op == OP_COUNT) begin
            hold_in.status = ST_OK;
         end else begin
            hold_in.status = ST_MISS;
         end
      end
      rsp_valid_in = move || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
      end else begin
         busy_ff       <= busy_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (move) begin
         rsp_ff <= hold_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hw/rtl/kjt_checker.sv @@
`include "keyed_job_table_with_compaction_defines.svh"

module kjt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input kjt_pkg::rsp_type rsp_data
);
   import kjt_pkg::*;

   logic req_take;
   logic rsp_miss_fields_zero;

   assign req_take = req_valid && !req_stall;
   assign rsp_miss_fields_zero = (rsp_data.slot_index == '0) && (rsp_data.key_out == '0)
      && (rsp_data.job_out == '0) && (rsp_data.state_out == '0);

   `KJT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `KJT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))
   // one word in flight: a taken word blocks the next one
   `KJT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_take, req_stall)
   `KJT_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_data.found, rsp_miss_fields_zero)

endmodule

bind keyed_job_table_with_compaction kjt_checker u_kjt_checker (.*);

@@ bench/tb_keyed_job_table_with_compaction.sv @@
module tb_keyed_job_table_with_compaction;
   import kjt_pkg::*;

   localparam logic [OP_W-1:0]    OP_RSVD_A     = 3'd6;
   localparam logic [OP_W-1:0]    OP_RSVD_B     = 3'd7;
   localparam logic [STATE_W-1:0] JOB_FINISHED  = 2'd1;
   localparam logic [STATE_W-1:0] JOB_SUSPENDED = 2'd2;
   localparam logic [STATE_W-1:0] JOB_KILLED    = 2'd3;

   localparam int MAX_GAP     = 14;
   localparam int LONG_HOLD   = 300;
   localparam int POOL_KEYS   = 20;
   localparam int POOL_JOBS   = 6;
   localparam int EPISODES    = 21;
   localparam int EPISODE_LEN = 50;
   localparam int DRILL_ROWS  = 21;

   localparam logic [$bits(rsp_type)-1:0] UNTYPED = '0;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_CHURN} mix_mode_type;

   // one stimulus word, plus the result typed in by hand when typed is set
   typedef struct packed {
      req_type w;
      logic    typed;
      rsp_type r;
   } drill_row_type;

   localparam drill_row_type DRILL [DRILL_ROWS] = '{
      // empty table
      {OP_COUNT,     22'h000000, 16'h0000, JOB_RUNNING, 1'b1,
       1'b0, 4'd0, 22'h000000, 16'h0000, JOB_RUNNING, 5'd0, ST_OK},
      {OP_QUERY_KEY, 22'h3FFFFF, 16'h0000, JOB_RUNNING, 1'b1,
       1'b0, 4'd0, 22'h000000, 16'h0000, JOB_RUNNING, 5'd0, ST_MISS},
      {OP_DELETE,    22'h000000, 16'hFFFF, JOB_KILLED, 1'b1,
       1'b0, 4'd0, 22'h000000, 16'h0000, JOB_RUNNING, 5'd0, ST_MISS},
      {OP_SET_STATE, 22'h000000, 16'h0000, JOB_KILLED, 1'b1,
       1'b0, 4'd0, 22'h000000, 16'h0000, JOB_RUNNING, 5'd0, ST_MISS},
      {OP_QUERY_JOB, 22'h000000, 16'hFFFF, JOB_RUNNING, 1'b1,
       1'b0, 4'd0, 22'h000000, 16'h0000, JOB_RUNNING, 5'd0, ST_MISS},
      {OP_RSVD_A,    22'h3FFFFF, 16'hFFFF, JOB_KILLED, 1'b1,
       1'b0, 4'd0, 22'h000000, 16'h0000, JOB_RUNNING, 5'd0, ST_MISS},
      {OP_RSVD_B,    22'h000000, 16'h0000, JOB_RUNNING, 1'b1,
       1'b0, 4'd0, 22'h000000, 16'h0000, JOB_RUNNING, 5'd0, ST_MISS},
      // extremes in, then a duplicate key
      {OP_INSERT,    22'h3FFFFF, 16'hFFFF, JOB_KILLED, 1'b1,
       1'b1, 4'd0, 22'h3FFFFF, 16'hFFFF, JOB_RUNNING, 5'd1, ST_OK},
      {OP_INSERT,    22'h000000, 16'h0000, JOB_RUNNING, 1'b1,
       1'b1, 4'd1, 22'h000000, 16'h0000, JOB_RUNNING, 5'd2, ST_OK},
      {OP_INSERT,    22'h3FFFFF, 16'h1234, JOB_RUNNING, 1'b1,
       1'b1, 4'd0, 22'h3FFFFF, 16'hFFFF, JOB_RUNNING, 5'd2, ST_MISS},
      // shared job number, state writes, lookups
      {OP_INSERT,    22'h2AAAAA, 16'h0000, JOB_SUSPENDED, 1'b0, UNTYPED},
      {OP_SET_STATE, 22'h000000, 16'h0000, JOB_KILLED, 1'b0, UNTYPED},
      {OP_SET_STATE, 22'h2AAAAA, 16'h5555, JOB_SUSPENDED, 1'b0, UNTYPED},
      {OP_QUERY_JOB, 22'h155555, 16'h0000, JOB_FINISHED, 1'b0, UNTYPED},
      {OP_QUERY_KEY, 22'h2AAAAA, 16'hAAAA, JOB_RUNNING, 1'b0, UNTYPED},
      // delete at the head shifts the rest down
      {OP_DELETE,    22'h3FFFFF, 16'h0000, JOB_RUNNING, 1'b0, UNTYPED},
      {OP_QUERY_KEY, 22'h000000, 16'h0000, JOB_RUNNING, 1'b0, UNTYPED},
      {OP_SET_STATE, 22'h155555, 16'h0000, JOB_FINISHED, 1'b1,
       1'b0, 4'd0, 22'h000000, 16'h0000, JOB_RUNNING, 5'd2, ST_MISS},
      {OP_COUNT,     22'h155555, 16'hAAAA, JOB_KILLED, 1'b0, UNTYPED},
      {OP_DELETE,    22'h2AAAAA, 16'h0000, JOB_RUNNING, 1'b0, UNTYPED},
      {OP_DELETE,    22'h000000, 16'h0000, JOB_RUNNING, 1'b0, UNTYPED}
   };

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // shadow copy of the job table
   entry_type  job_rows [TABLE_DEPTH];
   int         job_rows_used = 0;

   drill_row_type drill_marks [$];
   rsp_type       due_words [$];
   int            mismatches = 0;
   bit            quiet = 1'b0;
   bit            long_hold_req = 1'b0;

   keyed_job_table_with_compaction u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type row_word(input int pos, input logic [STAT_W-1:0] status);
      rsp_type r;
      r = '0;
      r.found      = 1'b1;
      r.slot_index = pos[SLOT_W-1:0];
      r.key_out    = PID_W'(job_rows[pos].key);
      r.job_out    = job_rows[pos].job;
      r.state_out  = job_rows[pos].state;
      r.status     = status;
      return r;
   endfunction

   // applies one command word to the shadow table, returns the result word
   function automatic rsp_type table_apply(input req_type w);
      rsp_type          r;
      int               pos;
      logic [KEY_W-1:0] key;
      key = w.pid_key[KEY_W-1:0];
      r   = '0;
      pos = -1;
      // scan downward so the lowest matching position wins
      for (int i = job_rows_used - 1; i >= 0; i--) begin
         if (w.operation == OP_QUERY_JOB ? job_rows[i].job == w.job_number
                                         : job_rows[i].key == key)
            pos = i;
      end
      case (w.operation)
         OP_INSERT: begin
            if (pos >= 0) begin
               r = row_word(pos, ST_MISS);
            end else if (job_rows_used >= TABLE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               job_rows[job_rows_used].key   = key;
               job_rows[job_rows_used].job   = w.job_number;
               job_rows[job_rows_used].state = JOB_RUNNING;
               r = row_word(job_rows_used, ST_OK);
               job_rows_used++;
            end
         end
         OP_DELETE: begin
            if (pos < 0) begin
               r.status = ST_MISS;
            end else begin
               r = row_word(pos, ST_OK);
               for (int i = pos; i < job_rows_used - 1; i++)
                  job_rows[i] = job_rows[i + 1];
               job_rows_used--;
            end
         end
         OP_SET_STATE: begin
            if (pos < 0) begin
               r.status = ST_MISS;
            end else begin
               job_rows[pos].state = w.new_state;
               r = row_word(pos, ST_OK);
            end
         end
         OP_QUERY_KEY, OP_QUERY_JOB: begin
            if (pos < 0)
               r.status = ST_MISS;
            else
               r = row_word(pos, ST_OK);
         end
         OP_COUNT: r.status = ST_OK;
         default:  r.status = ST_MISS;
      endcase
      r.entry_count = COUNT_W'(job_rows_used);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic send_word(input drill_row_type row, input int gap);
      drill_marks.push_back(row);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= row.w;
      do @(posedge clock); while (req_stall);
   endtask

   // request side feeds the shadow table, result side is checked in order
   always @(posedge clock) begin
      rsp_type       guess;
      rsp_type       want;
      drill_row_type mark;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            guess = table_apply(req_data);
            mark  = drill_marks.pop_front();
            due_words.push_back(mark.typed ? mark.r : guess);
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_words.size() == 0) begin
               $error("result word arrived with nothing pending");
               mismatches++;
            end else begin
               want = due_words.pop_front();
               check_field("found", 32'(want.found), 32'(rsp_data.found));
               check_field("slot_index", 32'(want.slot_index), 32'(rsp_data.slot_index));
               check_field("key_out", 32'(want.key_out), 32'(rsp_data.key_out));
               check_field("job_out", 32'(want.job_out), 32'(rsp_data.job_out));
               check_field("state_out", 32'(want.state_out), 32'(rsp_data.state_out));
               check_field("entry_count", 32'(want.entry_count),
                           32'(rsp_data.entry_count));
               check_field("status", 32'(want.status), 32'(rsp_data.status));
            end
         end
      end
   end

   // result side: no stall, or a stall raised right away and held past the next word or for the long hold
   initial begin
      int hold;
      rsp_stall <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            hold = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (hold != 0) begin
               rsp_stall <= 1'b1;
               do @(posedge clock); while (!rsp_valid);
               repeat (hold - 1) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      mix_mode_type     mode;
      drill_row_type    row;
      logic [PID_W-1:0] key_pool [POOL_KEYS];
      logic [JOB_W-1:0] job_pool [POOL_JOBS];
      int               pick;
      int               ins_share;
      int               del_share;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DRILL_ROWS; i++)
         send_word(DRILL[i], $urandom_range(0, MAX_GAP));

      // episodes over a small key pool so hits, duplicates and a full table occur
      for (int ep = 0; ep < EPISODES; ep++) begin
         mode  = (ep == 0) ? MIX_FILL : mix_mode_type'($urandom_range(0, 2));
         quiet = ($urandom_range(0, 3) == 0);
         if (ep == 4) begin
            quiet         = 1'b1;
            long_hold_req = 1'b1;
         end
         for (int i = 0; i < POOL_KEYS; i++)
            key_pool[i] = PID_W'($urandom());
         for (int i = 0; i < POOL_JOBS; i++)
            job_pool[i] = JOB_W'($urandom());
         ins_share = (mode == MIX_FILL) ? 60 : (mode == MIX_DRAIN) ? 15 : 30;
         del_share = (mode == MIX_FILL) ? 10 : (mode == MIX_DRAIN) ? 50 : 25;

         for (int n = 0; n < EPISODE_LEN; n++) begin
            row  = '0;
            pick = $urandom_range(0, 99);
            if (pick < ins_share) begin
               row.w.operation = OP_INSERT;
            end else if (pick < ins_share + del_share) begin
               row.w.operation = OP_DELETE;
            end else begin
               pick = $urandom_range(0, 19);
               if (pick < 6)       row.w.operation = OP_SET_STATE;
               else if (pick < 11) row.w.operation = OP_QUERY_KEY;
               else if (pick < 16) row.w.operation = OP_QUERY_JOB;
               else if (pick < 18) row.w.operation = OP_COUNT;
               else if (pick == 18) row.w.operation = OP_RSVD_A;
               else                row.w.operation = OP_RSVD_B;
            end
            row.w.pid_key    = ($urandom_range(0, 9) == 0) ? PID_W'($urandom())
                             : key_pool[$urandom_range(0, POOL_KEYS - 1)];
            row.w.job_number = ($urandom_range(0, 3) == 0) ? JOB_W'($urandom())
                             : job_pool[$urandom_range(0, POOL_JOBS - 1)];
            row.w.new_state  = STATE_W'($urandom_range(0, 3));
            send_word(row, quiet ? 0 : $urandom_range(0, MAX_GAP));
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (due_words.size() != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ keyed_job_table_with_compaction.f @@
+incdir+hw/rtl
hw/rtl/kjt_pkg.sv
hw/rtl/kjt_cell.sv
hw/rtl/keyed_job_table_with_compaction.sv
hw/rtl/kjt_checker.sv
bench/tb_keyed_job_table_with_compaction.sv
